@@ hw/rtl/scr_pkg.sv @@
// package for the sum checked chunk reassembler
// holds transaction payload types, status codes and sizing constants; no dependencies
package scr_pkg;

   // message store sizing
   localparam int MSG_DEPTH = 4096;
   localparam int ADDR_W    = $clog2(MSG_DEPTH);

   // packet framing
   localparam int HDR_LEN = 9;
   localparam int POS_MAX = 265;
   localparam logic [16:0] RECV_MAX = 17'h1FFFF;

   // front queue sizing
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // request codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_READ = 1'b1;

   // response kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // status codes
   localparam logic [3:0] ST_INCOMPLETE = 4'd0;
   localparam logic [3:0] ST_COMPLETE   = 4'd1;
   localparam logic [3:0] ST_SHORT      = 4'd2;
   localparam logic [3:0] ST_HEAD       = 4'd3;
   localparam logic [3:0] ST_BOUNDS     = 4'd4;
   localparam logic [3:0] ST_SUM        = 4'd5;
   localparam logic [3:0] ST_SEQUENCE   = 4'd6;
   localparam logic [3:0] ST_LENGTH     = 4'd7;
   localparam logic [3:0] ST_TOO_LONG   = 4'd8;

   typedef struct packed {
      logic        op;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  status;
      logic [12:0] message_length;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

@@ hw/rtl/scr_queue.sv @@
// front part: accepts request transactions into a short fifo
// depends on scr_pkg for req_type and queue sizing
module scr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scr_pkg::req_type req_payload,
   output logic             q_valid,
   output scr_pkg::req_type q_item,
   input  logic             q_pop
);
   import scr_pkg::*;

   req_type           slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]     count_ff, count_in;
   logic              push;
   logic              pop;

   assign req_stall = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

@@ hw/rtl/scr_engine.sv @@
// back part: packet parsing, judging, message store and response pipeline
// depends on scr_pkg for types, status codes and store sizing
module scr_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       head_byte,
   input  logic             q_valid,
   input  scr_pkg::req_type q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scr_pkg::rsp_type rsp_payload
);
   import scr_pkg::*;

   // per packet state
   logic [8:0]   pos_ff, pos_in;
   logic [55:0]  hdr_ff, hdr_in;
   logic         head_ok_ff, head_ok_in;
   logic [7:0]   sum_ff, sum_in;
   logic [7:0]   chk_ff, chk_in;
   logic         seen_ff, seen_in;
   // assembly state
   logic [15:0]  nseq_ff, nseq_in;
   logic [16:0]  recv_ff, recv_in;
   logic [15:0]  exp_ff, exp_in;

   logic [7:0]   mem_ff [MSG_DEPTH];

   // result stage and output register
   logic         s1_valid_ff, s1_valid_in;
   rsp_type      s1_rsp_ff, s1_rsp_in;
   logic         s1_read_ff;
   logic         s1_range_ff;
   logic [7:0]   rd_data_ff;
   logic         out_valid_ff;
   rsp_type      out_ff;

   logic         consume;
   logic         s1_move;
   logic         is_byte;
   logic [7:0]   b;

   // after-take values
   logic [8:0]   t_pos;
   logic [55:0]  t_hdr;
   logic         t_head_ok;
   logic [7:0]   t_sum;
   logic [7:0]   t_chk;
   logic         t_seen;

   // store write path
   logic [7:0]   chunk;
   logic [15:0]  w_seq;
   logic [15:0]  w_mlen;
   logic [9:0]   pay_end;
   logic [8:0]   off;
   logic [17:0]  base;
   logic [17:0]  limit;
   logic [17:0]  widx;
   logic         w_ok;
   logic         wr_en;
   logic [ADDR_W-1:0] wr_addr;

   // read path
   logic [17:0]  ridx;
   logic [ADDR_W-1:0] rd_addr;
   logic         rd_en;

   // judge
   logic [15:0]  j_seq;
   logic [15:0]  j_total;
   logic [15:0]  j_mlen;
   logic [7:0]   j_chunk;
   logic         j_first;
   logic [17:0]  j_sum18;
   logic [16:0]  j_recv;
   logic [15:0]  j_exp;
   logic [3:0]   j_status;
   logic [12:0]  j_len;
   logic         j_clear;
   logic         j_update;

   assign s1_move = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign consume = q_valid && (!s1_valid_ff || s1_move);
   assign q_pop   = consume;
   assign is_byte = (q_item.op == OP_BYTE);
   assign b       = q_item.data_byte;

   // take one packet byte
   always_comb begin
      t_pos     = (pos_ff < 9'(POS_MAX)) ? pos_ff + 9'd1 : pos_ff;
      t_hdr     = hdr_ff;
      t_head_ok = head_ok_ff;
      t_sum     = sum_ff;
      t_chk     = chk_ff;
      t_seen    = seen_ff;
      chunk     = hdr_ff[7:0];
      w_seq     = hdr_ff[55:40];
      w_mlen    = hdr_ff[23:8];
      pay_end   = 10'(HDR_LEN) + {2'b00, chunk};
      off       = pos_ff - 9'(HDR_LEN);
      base      = (w_seq == 16'd0) ? 18'd0 : {1'b0, recv_ff};
      limit     = (w_seq == 16'd0) ? {2'b00, w_mlen} : {2'b00, exp_ff};
      widx      = base + {9'b0, off};
      w_ok      = head_ok_ff && (w_seq == nseq_ff)
                  && !((w_seq == 16'd0) && ({1'b0, w_mlen} > 17'(MSG_DEPTH)))
                  && ((base + {10'b0, chunk}) <= limit)
                  && (widx < 18'(MSG_DEPTH));
      wr_en     = 1'b0;
      if (pos_ff == 9'd0) begin
         t_head_ok = (b == head_byte);
      end else if (pos_ff < 9'(HDR_LEN)) begin
         t_sum = sum_ff + b;
         if (pos_ff >= 9'd2) begin
            t_hdr = {hdr_ff[47:0], b};
         end
      end else if ({1'b0, pos_ff} < pay_end) begin
         t_sum = sum_ff + b;
         wr_en = consume && is_byte && w_ok;
      end else if ({1'b0, pos_ff} == pay_end) begin
         t_chk  = b;
         t_seen = 1'b1;
      end
   end

   assign wr_addr = widx[ADDR_W-1:0];

   // judge a packet on its last byte
   always_comb begin
      j_seq    = t_hdr[55:40];
      j_total  = t_hdr[39:24];
      j_mlen   = t_hdr[23:8];
      j_chunk  = t_hdr[7:0];
      j_first  = (j_seq == 16'd0);
      j_sum18  = (j_first ? 18'd0 : {1'b0, recv_ff}) + {10'b0, j_chunk};
      j_recv   = (j_sum18 > {1'b0, RECV_MAX}) ? RECV_MAX : j_sum18[16:0];
      j_exp    = j_first ? j_mlen : exp_ff;
      j_status = ST_INCOMPLETE;
      j_len    = '0;
      j_clear  = 1'b1;
      j_update = 1'b0;
      if (t_pos < 9'(HDR_LEN + 1)) begin
         j_status = ST_SHORT;
         j_clear  = 1'b0;
      end else if (!t_head_ok) begin
         j_status = ST_HEAD;
      end else if (!t_seen) begin
         j_status = ST_BOUNDS;
      end else if (t_chk != t_sum) begin
         j_status = ST_SUM;
      end else if (j_seq != nseq_ff) begin
         j_status = ST_SEQUENCE;
      end else if (j_first && ({1'b0, j_mlen} > 17'(MSG_DEPTH))) begin
         j_status = ST_TOO_LONG;
      end else if (j_seq == j_total - 16'd1) begin
         if (j_recv != {1'b0, j_exp}) begin
            j_status = ST_LENGTH;
         end else begin
            j_status = ST_COMPLETE;
            j_len    = j_recv[12:0];
         end
      end else begin
         j_status = ST_INCOMPLETE;
         j_clear  = 1'b0;
         j_update = 1'b1;
      end
   end

   // next state
   always_comb begin
      pos_in      = pos_ff;
      hdr_in      = hdr_ff;
      head_ok_in  = head_ok_ff;
      sum_in      = sum_ff;
      chk_in      = chk_ff;
      seen_in     = seen_ff;
      nseq_in     = nseq_ff;
      recv_in     = recv_ff;
      exp_in      = exp_ff;
      s1_valid_in = s1_move ? 1'b0 : s1_valid_ff;
      s1_rsp_in   = s1_rsp_ff;
      if (consume) begin
         if (is_byte) begin
            if (q_item.last_byte) begin
               pos_in      = '0;
               hdr_in      = '0;
               head_ok_in  = 1'b0;
               sum_in      = '0;
               chk_in      = '0;
               seen_in     = 1'b0;
               s1_valid_in = 1'b1;
               s1_rsp_in   = '{kind: KIND_STATUS, status: j_status,
                               message_length: j_len, read_data: 8'd0};
               if (j_clear) begin
                  nseq_in = '0;
                  recv_in = '0;
                  exp_in  = '0;
               end else if (j_update) begin
                  nseq_in = j_seq + 16'd1;
                  recv_in = j_recv;
                  exp_in  = j_exp;
               end
            end else begin
               pos_in      = t_pos;
               hdr_in      = t_hdr;
               head_ok_in  = t_head_ok;
               sum_in      = t_sum;
               chk_in      = t_chk;
               seen_in     = t_seen;
               s1_valid_in = 1'b0;
            end
         end else begin
            s1_valid_in = 1'b1;
            s1_rsp_in   = '{kind: KIND_READ, status: ST_INCOMPLETE,
                            message_length: 13'd0, read_data: 8'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_ff       <= '0;
         head_ok_ff   <= 1'b0;
         sum_ff       <= '0;
         chk_ff       <= '0;
         seen_ff      <= 1'b0;
         nseq_ff      <= '0;
         recv_ff      <= '0;
         exp_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         hdr_ff      <= hdr_in;
         head_ok_ff  <= head_ok_in;
         sum_ff      <= sum_in;
         chk_ff      <= chk_in;
         seen_ff     <= seen_in;
         nseq_ff     <= nseq_in;
         recv_ff     <= recv_in;
         exp_ff      <= exp_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_rsp_ff <= s1_rsp_in;
      if (consume) begin
         s1_read_ff  <= !is_byte;
         s1_range_ff <= (ridx < 18'(MSG_DEPTH));
      end
      if (s1_move) begin
         out_ff <= '{kind: s1_rsp_ff.kind, status: s1_rsp_ff.status,
                     message_length: s1_rsp_ff.message_length,
                     read_data: (s1_read_ff && s1_range_ff) ? rd_data_ff : 8'd0};
      end
   end

   // message store
   assign ridx    = {6'b0, q_item.read_index};
   assign rd_addr = ridx[ADDR_W-1:0];
   assign rd_en   = consume && !is_byte;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= b;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ hw/rtl/sum_checked_chunk_reassembler.sv @@
// top level of the sum checked chunk reassembler
// instantiates scr_queue and scr_engine, holds the head byte register; uses scr_pkg
//
// Packet bytes and store reads go in as request transactions, one per clock when nothing
// stalls. A four-entry fifo at the front decouples the request side from the engine,
// which handles one queued transaction per cycle while the response side does not stall
// (header capture, running sum, early store write, and on the last byte the full
// judgement), so the sustained rate is one transaction per cycle when nothing stalls. A
// status or read response passes from the fifo slot through the engine result stage,
// where the message store read is registered, to the output register that drives the
// rsp channel. Packet bytes without the last marker give no response. The message store
// is a single-port memory of MSG_DEPTH bytes, written by payload bytes and read by read
// requests; it needs no clearing pass and entries never written read back as undefined.
// The head byte register is written through the csr channel, which is always ready, and
// should only be written while the block is idle.
module sum_checked_chunk_reassembler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scr_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);
   import scr_pkg::*;

   logic [7:0] head_byte_ff;   // value required in packet byte zero
   logic       q_valid;
   req_type    q_item;
   logic       q_pop;

   // csr writes are always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_byte_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         head_byte_ff <= csr_data;
      end
   end

   // front: accept and queue request transactions
   scr_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // back: parse, judge, store and respond
   scr_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .head_byte   (head_byte_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ hw/rtl/scr_checker.sv @@
// port level checker for the sum checked chunk reassembler
// depends on scr_pkg; bound to sum_checked_chunk_reassembler below
module scr_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input scr_pkg::rsp_type rsp_payload
);
   import scr_pkg::*;

   // no response straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   // read responses carry no status or length
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_READ) |->
      (rsp_payload.status == ST_INCOMPLETE) && (rsp_payload.message_length == 13'd0))
      else $error("read response with status fields");

   // only a complete status carries a length and no status response carries data
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_STATUS) |->
      (rsp_payload.read_data == 8'd0)
      && ((rsp_payload.status == ST_COMPLETE) || (rsp_payload.message_length == 13'd0)))
      else $error("status response with stray fields");

endmodule

bind sum_checked_chunk_reassembler scr_checker u_scr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
